/* rtl/cda_pkg.sv */
package cda_pkg;

    localparam logic [13:0] MAX_YEAR   = 14'd9999;
    localparam logic [13:0] RST_YEAR   = 14'd2001;
    localparam logic [3:0]  RST_MONTH  = 4'd1;
    localparam logic [4:0]  RST_DAY    = 5'd1;

    // floor(y / 100) = (y * 5243) >> 19 for y < 16384
    localparam logic [12:0] DIV100_MUL = 13'd5243;
    localparam int          DIV100_SHR = 19;
    // floor(x / 12) = (x * 21846) >> 18 for x < 32768
    localparam logic [14:0] DIV12_MUL  = 15'd21846;
    localparam int          DIV12_SHR  = 18;

    typedef enum logic [1:0] {
        MODE_LOAD   = 2'd0,
        MODE_DAYS   = 2'd1,
        MODE_MONTHS = 2'd2,
        MODE_YEARS  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEAP,
        ST_EXEC,
        ST_MON_Q,
        ST_MON_R,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        LP_IDLE,
        LP_MUL,
        LP_CHK,
        LP_DONE
    } t_leap_st;

    typedef struct packed {
        logic done;
        logic leap;
    } t_leap_res;

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

/* rtl/calendar_date_arithmetic.sv */
// channel  | dir | handshake                  | payload
// s_axis   | in  | tvalid / tready            | tuser: mode; tdata: year, month, day, count
// m_axis   | out | tvalid / tready            | tuser: error; tdata: year, month, day
//
// one transfer in, one transfer out; not ready from acceptance until the result is handed
// to the output register. load and add years run the leap check, then the exec state; add
// months takes a quotient step, then a remainder step; a count or year rejected on entry goes
// straight to done; add days runs the day-step loop and reruns the shared leap unit
// (multiply by reciprocal, then remainder check) at every year boundary crossed.
// synchronous active-low reset restores 2001-01-01. a stalled output holds; the block
// starts the next item while the last result waits and stalls only to hand over its own.
module calendar_date_arithmetic (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // load_year, load_month, load_day, count, zeros
    input  logic [1:0]  i_s_axis_tuser,   // mode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // cur_year, cur_month, cur_day, zero
    output logic        o_m_axis_tuser    // error
);

    cda_pkg::t_state    r_state, n_state;
    cda_pkg::t_leap_res w_leap_res;

    logic [13:0] r_year;
    logic [3:0]  r_month;
    logic [4:0]  r_day;

    cda_pkg::t_mode r_mode;
    logic [14:0] r_cnt;
    logic        r_err;
    logic [13:0] r_wy;
    logic [3:0]  r_wm;
    logic [4:0]  r_wd;
    logic [11:0] r_q12;

    logic        r_ovalid;
    logic [13:0] r_oyear;
    logic [3:0]  r_omonth;
    logic [4:0]  r_oday;
    logic        r_oerr;

    cda_pkg::t_mode w_in_mode;
    logic [13:0] w_in_year;
    logic [3:0]  w_in_month;
    logic [4:0]  w_in_day;
    logic [14:0] w_in_cnt;
    logic signed [15:0] w_ny;
    logic        w_accept;
    logic        w_early_err;
    logic        w_out_free;

    logic [4:0]  w_len;
    logic [5:0]  w_d1;
    logic        w_over;
    logic        w_step;
    logic        w_roll_year;
    logic [14:0] w_mx;
    logic [29:0] w_mprod;
    logic [14:0] w_mrem;

    logic        w_leap_start;
    logic [13:0] w_leap_year;

    assign w_in_mode  = cda_pkg::t_mode'(i_s_axis_tuser);
    assign w_in_year  = i_s_axis_tdata[13:0];
    assign w_in_month = i_s_axis_tdata[17:14];
    assign w_in_day   = i_s_axis_tdata[22:18];
    assign w_in_cnt   = i_s_axis_tdata[37:23];

    assign w_ny = $signed({2'b00, r_year}) + $signed({w_in_cnt[14], w_in_cnt});

    always_comb begin
        case (w_in_mode)
            cda_pkg::MODE_LOAD:   w_early_err = (w_in_year > cda_pkg::MAX_YEAR);
            cda_pkg::MODE_DAYS:   w_early_err = w_in_cnt[14];
            cda_pkg::MODE_MONTHS: w_early_err = w_in_cnt[14];
            cda_pkg::MODE_YEARS:  w_early_err = w_ny[15] ||
                                                (w_ny[14:0] > 15'(cda_pkg::MAX_YEAR));
            default:              w_early_err = 1'b1;
        endcase
    end

    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_ovalid || i_m_axis_tready;

    assign w_len       = cda_pkg::month_len(r_wm, w_leap_res.leap);
    assign w_d1        = {1'b0, r_wd} + 6'd1;
    assign w_over      = w_d1 > {1'b0, w_len};
    assign w_step      = (r_mode == cda_pkg::MODE_DAYS) && (r_cnt != 15'd0);
    assign w_roll_year = w_step && w_over && (r_wm >= 4'd12);

    assign w_mx    = 15'(r_wm) - 15'd1 + r_cnt;
    assign w_mprod = 30'(w_mx) * 30'(cda_pkg::DIV12_MUL);
    assign w_mrem  = w_mx - 15'(r_q12) * 15'd12;

    cda_leap u_leap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_leap_start),
        .i_year  (w_leap_year),
        .o_res   (w_leap_res)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            cda_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (w_early_err) begin
                        n_state = cda_pkg::ST_DONE;
                    end else if (w_in_mode == cda_pkg::MODE_MONTHS) begin
                        n_state = cda_pkg::ST_MON_Q;
                    end else begin
                        n_state = cda_pkg::ST_LEAP;
                    end
                end
            end
            cda_pkg::ST_LEAP: begin
                if (w_leap_res.done) n_state = cda_pkg::ST_EXEC;
            end
            cda_pkg::ST_EXEC: begin
                if (!w_step) begin
                    n_state = cda_pkg::ST_DONE;
                end else if (w_roll_year) begin
                    n_state = (r_wy == cda_pkg::MAX_YEAR) ? cda_pkg::ST_DONE
                                                          : cda_pkg::ST_LEAP;
                end
            end
            cda_pkg::ST_MON_Q: n_state = cda_pkg::ST_MON_R;
            cda_pkg::ST_MON_R: n_state = cda_pkg::ST_DONE;
            cda_pkg::ST_DONE: begin
                if (w_out_free) n_state = cda_pkg::ST_IDLE;
            end
            default: n_state = cda_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_s_axis_tready = i_rst_n && (r_state == cda_pkg::ST_IDLE);
        w_leap_start    = 1'b0;
        w_leap_year     = r_wy + 14'd1;
        case (r_state)
            cda_pkg::ST_IDLE: begin
                w_leap_start = w_accept && !w_early_err &&
                               (w_in_mode != cda_pkg::MODE_MONTHS);
                case (w_in_mode)
                    cda_pkg::MODE_LOAD:  w_leap_year = w_in_year;
                    cda_pkg::MODE_YEARS: w_leap_year = w_ny[13:0];
                    default:             w_leap_year = r_year;
                endcase
            end
            cda_pkg::ST_EXEC: begin
                w_leap_start = w_roll_year && (r_wy != cda_pkg::MAX_YEAR);
            end
            default: begin
                w_leap_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= cda_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
            r_year   <= cda_pkg::RST_YEAR;
            r_month  <= cda_pkg::RST_MONTH;
            r_day    <= cda_pkg::RST_DAY;
        end else begin
            r_state <= n_state;
            if (r_state == cda_pkg::ST_DONE && w_out_free) begin
                r_ovalid <= 1'b1;
                if (!r_err) begin
                    r_year  <= r_wy;
                    r_month <= r_wm;
                    r_day   <= r_wd;
                end
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            cda_pkg::ST_IDLE: begin
                if (w_accept) begin
                    r_mode <= w_in_mode;
                    r_cnt  <= w_in_cnt;
                    r_err  <= w_early_err;
                    case (w_in_mode)
                        cda_pkg::MODE_LOAD: begin
                            r_wy <= w_in_year;
                            r_wm <= w_in_month;
                            r_wd <= w_in_day;
                        end
                        cda_pkg::MODE_YEARS: begin
                            r_wy <= w_ny[13:0];
                            r_wm <= r_month;
                            r_wd <= r_day;
                        end
                        default: begin
                            r_wy <= r_year;
                            r_wm <= r_month;
                            r_wd <= r_day;
                        end
                    endcase
                end
            end
            cda_pkg::ST_EXEC: begin
                case (r_mode)
                    cda_pkg::MODE_LOAD: begin
                        if (r_wm < 4'd1 || r_wm > 4'd12 || r_wd == 5'd0 || r_wd > w_len)
                            r_err <= 1'b1;
                    end
                    cda_pkg::MODE_DAYS: begin
                        if (w_step) begin
                            r_cnt <= r_cnt - 15'd1;
                            if (w_over) begin
                                r_wd <= 5'd1;
                                if (r_wm >= 4'd12) begin
                                    r_wm <= 4'd1;
                                    if (r_wy == cda_pkg::MAX_YEAR) r_err <= 1'b1;
                                    else r_wy <= r_wy + 14'd1;
                                end else begin
                                    r_wm <= r_wm + 4'd1;
                                end
                            end else begin
                                r_wd <= w_d1[4:0];
                            end
                        end
                    end
                    cda_pkg::MODE_YEARS: begin
                        if (r_wm == 4'd2 && r_wd == 5'd29 && !w_leap_res.leap) begin
                            r_wm <= 4'd3;
                            r_wd <= 5'd1;
                        end
                    end
                    default: begin
                        r_err <= r_err;
                    end
                endcase
            end
            cda_pkg::ST_MON_Q: begin
                r_q12 <= w_mprod[cda_pkg::DIV12_SHR +: 12];
            end
            cda_pkg::ST_MON_R: begin
                r_wm <= w_mrem[3:0] + 4'd1;
            end
            cda_pkg::ST_DONE: begin
                if (w_out_free) begin
                    r_oerr <= r_err;
                    if (r_err) begin
                        r_oyear  <= r_year;
                        r_omonth <= r_month;
                        r_oday   <= r_day;
                    end else begin
                        r_oyear  <= r_wy;
                        r_omonth <= r_wm;
                        r_oday   <= r_wd;
                    end
                end
            end
            default: begin
                r_err <= r_err;
            end
        endcase
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {1'b0, r_oday, r_omonth, r_oyear};
    assign o_m_axis_tuser  = r_oerr;

endmodule

/* rtl/cda_leap.sv */
module cda_leap (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [13:0]         i_year,
    output cda_pkg::t_leap_res  o_res
);

    cda_pkg::t_leap_st r_st, n_st;
    logic [13:0] r_year;
    logic [7:0]  r_q;
    logic        r_leap;
    logic [26:0] w_prod;
    logic [13:0] w_rem;
    logic        w_leap;

    assign w_prod = 27'(r_year) * 27'(cda_pkg::DIV100_MUL);
    assign w_rem  = r_year - 14'(r_q) * 14'd100;
    assign w_leap = (r_year[1:0] == 2'd0) && ((w_rem != 14'd0) || (r_q[1:0] == 2'd0));

    always_comb begin
        n_st = r_st;
        case (r_st)
            cda_pkg::LP_IDLE: begin
                if (i_start) n_st = cda_pkg::LP_MUL;
            end
            cda_pkg::LP_MUL:  n_st = cda_pkg::LP_CHK;
            cda_pkg::LP_CHK:  n_st = cda_pkg::LP_DONE;
            cda_pkg::LP_DONE: n_st = cda_pkg::LP_IDLE;
            default:          n_st = cda_pkg::LP_IDLE;
        endcase
    end

    always_comb begin
        o_res.done = (r_st == cda_pkg::LP_DONE);
        o_res.leap = r_leap;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= cda_pkg::LP_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) r_year <= i_year;
        if (r_st == cda_pkg::LP_MUL) r_q <= w_prod[cda_pkg::DIV100_SHR +: 8];
        if (r_st == cda_pkg::LP_CHK) r_leap <= w_leap;
    end

endmodule
